FILE: sv/mad_pkg.sv
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types and constants for the multichannel averaging decimator.
// ----------------------------------------------------------------------------
package mad_pkg;

   localparam int CH_W         = 3;
   localparam int SAMPLE_BITS  = 24;
   localparam int SUM_W        = 40;
   localparam int CNT_W        = 16;
   localparam int FRAC_W       = 8;
   localparam int AVG_W        = 32;
   localparam int DIVIDEND_W   = SUM_W + FRAC_W;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CHCOUNT_W    = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIM_FACTOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_MODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECTED_CH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_COUNT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_QUOTA     = 3'd5;

   typedef struct packed {
      logic [CH_W-1:0]               channel;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [AVG_W-1:0] average;
      logic [CH_W-1:0]         out_channel;
      logic                    row_end;
      logic                    quota_reached;
   } rsp_payload_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [CNT_W-1:0]      divisor;
   } div_req_type;

endpackage

FILE: sv/mad_div.sv
// ----------------------------------------------------------------------------
// mad_div
// Restoring unsigned divider, one quotient bit per cycle. Returns the low
// AVG_W bits of the quotient.
// ----------------------------------------------------------------------------
module mad_div (
   input  logic                               clock,
   input  logic                               reset,
   input  mad_pkg::div_req_type               div_req,
   output logic                               div_done,
   output logic [mad_pkg::AVG_W-1:0]          div_quotient
);

   localparam int STEP_W = $clog2(mad_pkg::DIVIDEND_W + 1);

   logic [mad_pkg::CNT_W-1:0]      rem_ff;
   logic [mad_pkg::DIVIDEND_W-1:0] dq_ff;
   logic [mad_pkg::CNT_W-1:0]      divisor_ff;
   logic [STEP_W-1:0]              step_ff;
   logic                           busy_ff;
   logic                           done_ff;

   logic [mad_pkg::CNT_W:0]        shifted;
   logic [mad_pkg::CNT_W:0]        trial;
   logic                           ge;

   assign shifted = {rem_ff, dq_ff[mad_pkg::DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign ge      = shifted >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(mad_pkg::DIVIDEND_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= '0;
         dq_ff      <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial[mad_pkg::CNT_W-1:0] : shifted[mad_pkg::CNT_W-1:0];
         dq_ff  <= {dq_ff[mad_pkg::DIVIDEND_W-2:0], ge};
      end
   end

   assign div_done     = done_ff;
   assign div_quotient = dq_ff[mad_pkg::AVG_W-1:0];

endmodule

FILE: sv/multichannel_average_decimator.sv
// ----------------------------------------------------------------------------
// multichannel_average_decimator
// Boxcar averaging decimator over interleaved channels. Per-channel sum and
// count live in one synchronous memory, read-modify-written per averaged sample.
// ----------------------------------------------------------------------------
// Timing: a pass-through result is registered by the finish state; an averaged
//   result goes through read, update, divider start, the serial divide, capture.
// Flow: one transaction at a time, as the input is ready only in idle. A skipped
//   or dropped sample keeps it idle; one with no average returns after read and
//   update; result back-pressure holds the finish state.
// Reset: synchronous; resets control and configuration, clears per-channel valid bits.
module multichannel_average_decimator #(
   parameter int CHANNEL_SLOTS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mad_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mad_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_we,
   input  logic [mad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mad_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W   = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
   localparam int ENTRY_W = mad_pkg::SUM_W + mad_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // configuration
   logic [mad_pkg::CHCOUNT_W-1:0] channel_count_ff;
   logic [mad_pkg::CNT_W-1:0]     decim_factor_ff;
   logic                          single_mode_ff;
   logic [mad_pkg::CH_W-1:0]      selected_ch_ff;
   logic [31:0]                   skip_left_ff;
   logic [31:0]                   quota_left_ff;

   // working registers
   logic [mad_pkg::CH_W-1:0]        cur_ch_ff;
   logic signed [mad_pkg::SAMPLE_BITS-1:0] cur_sample_ff;
   logic [mad_pkg::SUM_W-1:0]       upd_sum_ff;
   logic [mad_pkg::CNT_W-1:0]       upd_cnt_ff;
   logic [mad_pkg::AVG_W-1:0]       quot_ff;
   logic                            neg_ff;
   logic                            quota_hit_ff;
   logic                            div_start_ff;
   logic [mad_pkg::DIVIDEND_W-1:0]  dividend_ff;
   logic [mad_pkg::CNT_W-1:0]       divisor_ff;

   logic                            rsp_valid_ff;
   mad_pkg::rsp_payload_type        rsp_data_ff;

   // memory
   logic [ENTRY_W-1:0]       mem_ff [CHANNEL_SLOTS];
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic [CHANNEL_SLOTS-1:0] valid_ff;

   logic [IDX_W-1:0]        rd_idx;
   logic [IDX_W-1:0]        cur_idx;
   logic                    accept;
   logic                    ch_in_range;
   logic                    pass_through;
   logic [mad_pkg::SUM_W-1:0] old_sum;
   logic [mad_pkg::CNT_W-1:0] old_cnt;
   logic [mad_pkg::SUM_W-1:0] sample_ext;
   logic                    emit;
   logic [mad_pkg::SUM_W-1:0] sum_mag;
   logic                    mem_we;
   logic [ENTRY_W-1:0]      mem_wdata;
   logic [mad_pkg::AVG_W-1:0] pt_value;
   logic [mad_pkg::AVG_W-1:0] avg_value;
   logic                    row_end;
   logic                    rsp_free;

   mad_pkg::div_req_type    div_req;
   logic                    div_done;
   logic [mad_pkg::AVG_W-1:0] div_quotient;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign rd_idx       = IDX_W'(req_data.channel);
   assign cur_idx      = IDX_W'(cur_ch_ff);
   assign ch_in_range  = {29'd0, req_data.channel} < 32'(CHANNEL_SLOTS);
   assign pass_through = (decim_factor_ff <= mad_pkg::CNT_W'(1));
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   // a channel never written reads as zero
   assign old_sum = valid_ff[cur_idx] ? rd_data_ff[ENTRY_W-1:mad_pkg::CNT_W] : '0;
   assign old_cnt = valid_ff[cur_idx] ? rd_data_ff[mad_pkg::CNT_W-1:0] : '0;
   assign sample_ext = {{(mad_pkg::SUM_W-mad_pkg::SAMPLE_BITS){cur_sample_ff[
                        mad_pkg::SAMPLE_BITS-1]}}, cur_sample_ff};

   assign emit    = (upd_cnt_ff != '0) && (upd_cnt_ff >= decim_factor_ff);
   assign sum_mag = upd_sum_ff[mad_pkg::SUM_W-1] ? (~upd_sum_ff + 1'b1) : upd_sum_ff;

   assign mem_we    = (state_ff == ST_WRITE);
   assign mem_wdata = emit ? '0 : {upd_sum_ff, upd_cnt_ff};

   assign pt_value  = mad_pkg::AVG_W'($signed({req_data.sample,
                                               {mad_pkg::FRAC_W{1'b0}}}));
   assign avg_value = neg_ff ? (~quot_ff + 1'b1) : quot_ff;
   assign row_end   = single_mode_ff ||
                      ({1'b0, cur_ch_ff} + 4'd1 == channel_count_ff);

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = dividend_ff;
   assign div_req.divisor  = divisor_ff;

   mad_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_idx];
      if (mem_we) begin
         mem_ff[cur_idx] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         channel_count_ff <= mad_pkg::CHCOUNT_W'(1);
         decim_factor_ff  <= mad_pkg::CNT_W'(1);
         single_mode_ff   <= 1'b0;
         selected_ch_ff   <= '0;
         skip_left_ff     <= '0;
         quota_left_ff    <= '0;
         valid_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         div_start_ff     <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;

         if (csr_we) begin
            unique case (csr_index)
               mad_pkg::CSR_CHANNEL_COUNT:
                  channel_count_ff <= csr_wdata[mad_pkg::CHCOUNT_W-1:0];
               mad_pkg::CSR_DECIM_FACTOR:
                  decim_factor_ff <= csr_wdata[mad_pkg::CNT_W-1:0];
               mad_pkg::CSR_SINGLE_MODE:   single_mode_ff <= csr_wdata[0];
               mad_pkg::CSR_SELECTED_CH:   selected_ch_ff <= csr_wdata[mad_pkg::CH_W-1:0];
               mad_pkg::CSR_SKIP_COUNT:    skip_left_ff   <= csr_wdata;
               mad_pkg::CSR_SAVE_QUOTA:    quota_left_ff  <= csr_wdata;
               default: ;
            endcase
         end

         // the finish state reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_ch_ff     <= req_data.channel;
                  cur_sample_ff <= req_data.sample;
                  if (skip_left_ff != '0) begin
                     skip_left_ff <= skip_left_ff - 1'b1;
                  end else if (quota_left_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else if (single_mode_ff && (req_data.channel != selected_ch_ff)) begin
                     state_ff <= ST_IDLE;
                  end else if (pass_through) begin
                     quot_ff       <= pt_value;
                     neg_ff        <= 1'b0;
                     quota_left_ff <= quota_left_ff - 1'b1;
                     quota_hit_ff  <= (quota_left_ff == 32'd1);
                     state_ff      <= ST_FINISH;
                  end else if (ch_in_range) begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               upd_sum_ff <= old_sum + sample_ext;
               upd_cnt_ff <= old_cnt + 1'b1;
               state_ff   <= ST_WRITE;
            end
            ST_WRITE: begin
               valid_ff[cur_idx] <= 1'b1;
               if (emit) begin
                  dividend_ff   <= {sum_mag, {mad_pkg::FRAC_W{1'b0}}};
                  divisor_ff    <= upd_cnt_ff;
                  neg_ff        <= upd_sum_ff[mad_pkg::SUM_W-1];
                  div_start_ff  <= 1'b1;
                  quota_left_ff <= quota_left_ff - 1'b1;
                  quota_hit_ff  <= (quota_left_ff == 32'd1);
                  state_ff      <= ST_DIV;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  quot_ff  <= div_quotient;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.average         <= avg_value;
                  rsp_data_ff.out_channel     <= cur_ch_ff;
                  rsp_data_ff.row_end         <= row_end;
                  rsp_data_ff.quota_reached   <= quota_hit_ff;
                  state_ff                    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> ($past(state_ff) == ST_READ))
      else $error("memory write-back without a preceding read");

   a_quota_spent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.quota_reached && !csr_we) |=>
         (quota_left_ff == '0) || $past(rsp_ready))
      else $error("quota left non-zero while a quota-reached transaction waits");

endmodule
